FILE: sv/rsvc_pkg.sv
package rsvc_pkg;

  localparam int unsigned TIME_W     = 64;
  localparam int unsigned RATE_W     = 34;
  localparam int unsigned NEW_RATE_W = 33;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned PROD_W     = HALF_W + RATE_W;
  localparam int unsigned ACC_W      = TIME_W + RATE_W;

  typedef enum logic [1:0] {
    KIND_L2G  = 2'd0,
    KIND_STEP = 2'd1,
    KIND_RATE = 2'd2,
    KIND_G2L  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FWD_DIFF,
    OP_INV_DIFF,
    OP_INV_LC,
    OP_ABS,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_ACC,
    OP_NEG,
    OP_ADD_GB,
    OP_SUB_LC,
    OP_FWD_OUT,
    OP_LATCH,
    OP_DIV_INIT,
    OP_DIV_STEP
  } dp_op_e;

  typedef enum logic {
    OUT_NONE = 1'b0,
    OUT_INV  = 1'b1
  } out_sel_e;

  typedef struct packed {
    dp_op_e   op;
    logic     add_step;
    logic     set_rate;
    out_sel_e inv_out;
  } dp_cmd_t;

endpackage

FILE: sv/rsvc_ctrl.sv
module rsvc_ctrl
  import rsvc_pkg::*;
#(
  parameter int unsigned RATE_FRACTION_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] kind_i,
  output logic       busy_o,
  output dp_cmd_t    cmd_o
);

  localparam int unsigned NUM_W = TIME_W + RATE_FRACTION_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FWD_DIFF,
    S_INV_DIFF,
    S_INV_LC,
    S_ABS,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_ACC,
    S_NEG,
    S_ADD_GB,
    S_SUB_LC,
    S_FINISH,
    S_DIV_INIT,
    S_DIV,
    S_INV_OUT
  } state_e;

  state_e             state_q;
  kind_e              kind_q;
  logic   [CNT_W-1:0] cnt_q;
  logic               accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // Advance the sequence; capture the kind at accept and count divider steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= KIND_L2G;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            kind_q  <= kind_e'(kind_i);
            state_q <= (kind_e'(kind_i) == KIND_G2L) ? S_INV_DIFF : S_FWD_DIFF;
          end
        end
        S_FWD_DIFF: state_q <= S_ABS;
        S_INV_DIFF: state_q <= S_INV_LC;
        S_INV_LC:   state_q <= S_ABS;
        S_ABS:      state_q <= (kind_q == KIND_G2L) ? S_DIV_INIT : S_MUL_LO;
        S_MUL_LO:   state_q <= S_MUL_HI;
        S_MUL_HI:   state_q <= S_MUL_ACC;
        S_MUL_ACC:  state_q <= S_NEG;
        S_NEG:      state_q <= S_ADD_GB;
        S_ADD_GB:   state_q <= S_SUB_LC;
        S_SUB_LC:   state_q <= S_FINISH;
        S_FINISH:   state_q <= S_IDLE;
        S_DIV_INIT: begin
          cnt_q   <= CNT_W'(NUM_W - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_INV_OUT;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_INV_OUT:  state_q <= S_IDLE;
        default:    state_q <= S_IDLE;
      endcase
    end
  end

  // Decode the datapath command from the state
  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = OP_NONE;
    cmd_o.inv_out  = OUT_NONE;
    unique case (state_q)
      S_IDLE:     cmd_o.op = accept ? OP_LOAD : OP_NONE;
      S_FWD_DIFF: cmd_o.op = OP_FWD_DIFF;
      S_INV_DIFF: cmd_o.op = OP_INV_DIFF;
      S_INV_LC:   cmd_o.op = OP_INV_LC;
      S_ABS:      cmd_o.op = OP_ABS;
      S_MUL_LO:   cmd_o.op = OP_MUL_LO;
      S_MUL_HI:   cmd_o.op = OP_MUL_HI;
      S_MUL_ACC:  cmd_o.op = OP_MUL_ACC;
      S_NEG:      cmd_o.op = OP_NEG;
      S_ADD_GB:   cmd_o.op = OP_ADD_GB;
      S_SUB_LC:   cmd_o.op = OP_SUB_LC;
      S_FINISH: begin
        cmd_o.op       = (kind_q == KIND_L2G) ? OP_FWD_OUT : OP_LATCH;
        cmd_o.add_step = (kind_q == KIND_STEP);
        cmd_o.set_rate = (kind_q == KIND_RATE);
      end
      S_DIV_INIT: cmd_o.op = OP_DIV_INIT;
      S_DIV:      cmd_o.op = OP_DIV_STEP;
      S_INV_OUT: begin
        cmd_o.op      = OP_FWD_OUT;
        cmd_o.inv_out = OUT_INV;
      end
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_DIV_STEP) |=> (cmd_o.op == OP_DIV_STEP || state_q == S_INV_OUT))
    else $error("divider left its loop early");

  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_FWD_OUT || cmd_o.op == OP_LATCH) |=> !busy_o)
    else $error("sequence did not end after its last step");

endmodule

FILE: sv/rsvc_dpath.sv
module rsvc_dpath
  import rsvc_pkg::*;
#(
  parameter int unsigned      RATE_FRACTION_BITS = 32,
  parameter logic [RATE_W-1:0] NOMINAL_RATE      = 34'h1_0000_0000
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  input  logic                  cfg_we_i,
  input  logic [TIME_W-1:0]     cfg_wdata_i,
  input  logic [TIME_W-1:0]     timestamp_i,
  input  logic [TIME_W-1:0]     step_ns_i,
  input  logic [NEW_RATE_W-1:0] new_rate_i,
  output logic                  done_o,
  output logic [TIME_W-1:0]     converted_time_o
);

  localparam int unsigned F     = RATE_FRACTION_BITS;
  localparam int unsigned NUM_W = TIME_W + F;

  // Clock state and configuration
  logic [TIME_W-1:0]     lc_q, local_base_q, global_base_q;
  logic [RATE_W-1:0]     rate_q;

  // Working registers
  logic [TIME_W-1:0]     ts_q, step_q, res_q, mag_q, quo_q, out_q;
  logic [NEW_RATE_W-1:0] new_rate_q;
  logic                  neg_q, done_q;
  logic [PROD_W-1:0]     prod_q;
  logic [ACC_W-1:0]      acc_q;
  logic [RATE_W-1:0]     rem_q;
  logic [NUM_W-1:0]      num_q;

  logic [RATE_W:0]       rem_sh;
  logic                  rem_ge;
  logic [TIME_W-1:0]     q_eff;
  logic [TIME_W-1:0]     inv_res;

  // One restoring divide step
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, rate_q});

  // Apply sign of the quotient and add the local base
  assign q_eff   = (rate_q == '0) ? '0 : quo_q;
  assign inv_res = local_base_q + (q_eff ^ {TIME_W{neg_q}}) + TIME_W'(neg_q);

  // Hold the clock state and the correction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q          <= '0;
      local_base_q  <= '0;
      global_base_q <= '0;
      rate_q        <= NOMINAL_RATE;
      done_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lc_q <= cfg_wdata_i;
      end
      done_q <= (cmd_i.op == OP_FWD_OUT);
      if (cmd_i.op == OP_LATCH) begin
        local_base_q  <= ts_q;
        global_base_q <= res_q + (cmd_i.add_step ? step_q : '0);
        if (cmd_i.set_rate && (new_rate_q != '0)) begin
          rate_q <= RATE_W'(new_rate_q);
        end
      end
    end
  end

  // Run the arithmetic steps
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        ts_q       <= timestamp_i;
        step_q     <= step_ns_i;
        new_rate_q <= new_rate_i;
      end
      OP_FWD_DIFF: res_q <= ts_q - local_base_q;
      OP_INV_DIFF: res_q <= ts_q - global_base_q;
      OP_INV_LC:   res_q <= res_q + lc_q;
      OP_ABS: begin
        neg_q <= res_q[TIME_W-1];
        mag_q <= res_q[TIME_W-1] ? (~res_q + 1'b1) : res_q;
      end
      OP_MUL_LO:   prod_q <= PROD_W'(mag_q[HALF_W-1:0] * rate_q);
      OP_MUL_HI: begin
        acc_q  <= ACC_W'(prod_q);
        prod_q <= PROD_W'(mag_q[TIME_W-1:HALF_W] * rate_q);
      end
      OP_MUL_ACC:  acc_q <= acc_q + {prod_q, {HALF_W{1'b0}}};
      OP_NEG: begin
        if (neg_q) begin
          acc_q <= ~acc_q + 1'b1;
        end
      end
      OP_ADD_GB:   res_q <= acc_q[F +: TIME_W] + global_base_q;
      OP_SUB_LC:   res_q <= res_q - lc_q;
      OP_FWD_OUT:  out_q <= (cmd_i.inv_out == OUT_INV) ? inv_res : res_q;
      OP_DIV_INIT: begin
        num_q <= {mag_q, {F{1'b0}}};
        rem_q <= '0;
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        rem_q <= rem_ge ? RATE_W'(rem_sh - {1'b0, rate_q}) : rem_sh[RATE_W-1:0];
        quo_q <= {quo_q[TIME_W-2:0], rem_ge};
      end
      default: begin
      end
    endcase
  end

  assign done_o           = done_q;
  assign converted_time_o = out_q;

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd_i.op == OP_FWD_OUT))
    else $error("result strobe without an output step");

endmodule

FILE: sv/rate_scaled_virtual_clock_unit.sv
// Local-to-global conversion gives its result once its multiply steps are done;
// global-to-local gives it once the divider has run (one divider bit a cycle).
// Step and rate items return busy low once their bases are latched and give no result.
// A new item is taken only while busy_o is low, once the previous item has finished.
// Reset (rst_ni low, asynchronous): bases zero, rate NOMINAL_RATE, correction zero.
// The result is on converted_time_o for the one cycle done_o is high; it cannot be stalled.
module rate_scaled_virtual_clock_unit
  import rsvc_pkg::*;
#(
  parameter int unsigned      RATE_FRACTION_BITS = 32,
  parameter logic [33:0]      NOMINAL_RATE       = 34'h1_0000_0000
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                  [1:0]  kind_i,
  input  logic signed           [63:0] timestamp_i,
  input  logic signed           [63:0] step_ns_i,
  input  logic                  [32:0] new_rate_i,
  input  logic                         cfg_we_i,
  input  logic signed           [63:0] cfg_wdata_i,
  output logic                         done_o,
  output logic signed           [63:0] converted_time_o
);

  dp_cmd_t           cmd;
  logic [TIME_W-1:0] conv;

  // Sequence the steps of each item
  rsvc_ctrl #(
    .RATE_FRACTION_BITS(RATE_FRACTION_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .kind_i (kind_i),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  // Hold clock state and do the arithmetic
  rsvc_dpath #(
    .RATE_FRACTION_BITS(RATE_FRACTION_BITS),
    .NOMINAL_RATE      (NOMINAL_RATE)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     ($unsigned(cfg_wdata_i)),
    .timestamp_i     ($unsigned(timestamp_i)),
    .step_ns_i       ($unsigned(step_ns_i)),
    .new_rate_i      (new_rate_i),
    .done_o          (done_o),
    .converted_time_o(conv)
  );

  assign converted_time_o = $signed(conv);

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb
  import rsvc_pkg::*;
();

  localparam logic [RATE_W-1:0] NOM_RATE     = 34'h1_0000_0000;
  localparam logic [63:0]       MAX_TIME     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]       MIN_TIME     = 64'h8000_0000_0000_0000;
  localparam int                SETTLE_CYCLES = 12;
  localparam int                TAIL_CYCLES   = 120;
  localparam int                ITEMS_PER_PHASE = 300;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  kind_e                kind_i;
  logic signed [63:0]   timestamp_i;
  logic signed [63:0]   step_ns_i;
  logic [32:0]          new_rate_i;
  logic                 cfg_we_i;
  logic signed [63:0]   cfg_wdata_i;
  logic                 done_o;
  logic signed [63:0]   converted_time_o;

  // Clock state mirrored on the testbench side
  logic [63:0]          corr_ns;
  logic [63:0]          lbase_mirror;
  logic [63:0]          gbase_mirror;
  logic [RATE_W-1:0]    cur_rate;

  logic [63:0]          expected_times [$];
  logic [63:0]          want_time;
  int unsigned          mismatch_count;
  bit                   idle_on;

  rate_scaled_virtual_clock_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .kind_i           (kind_i),
    .timestamp_i      (timestamp_i),
    .step_ns_i        (step_ns_i),
    .new_rate_i       (new_rate_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .converted_time_o (converted_time_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  // Abort a hung run
  initial begin
    #25_000_000;
    $display("tb failed");
    $finish;
  end

  // Local to global: scale the distance from the local base by the Q32 rate
  function automatic logic [63:0] to_global(logic [63:0] t);
    logic [63:0]         offset;
    logic signed [127:0] offset_wide;
    logic signed [127:0] prod;
    offset      = t - lbase_mirror;
    offset_wide = $signed(offset);
    prod        = offset_wide * $signed({94'b0, cur_rate});
    // keep the floor of the product over 2^32, wrapped to 64 bits
    return prod[95:32] + gbase_mirror - corr_ns;
  endfunction

  // Global to local: divide the magnitude, then restore the sign
  function automatic logic [63:0] to_local(logic [63:0] t);
    logic [63:0] span;
    logic [63:0] mag;
    logic [95:0] quo;
    logic [63:0] q;
    span = t - gbase_mirror + corr_ns;
    mag  = span[63] ? -span : span;
    if (cur_rate == '0) return lbase_mirror;
    quo = {mag, 32'b0} / {62'b0, cur_rate};
    q   = quo[63:0];
    return lbase_mirror + (span[63] ? -q : q);
  endfunction

  // Advance the mirrored clock by one item; report a result if the item makes one
  task automatic predict_item(input kind_e k, input logic [63:0] ts, input logic [63:0] stp,
                              input logic [32:0] nr, output bit has_time,
                              output logic [63:0] time_val);
    logic [63:0] now;
    has_time = 1'b0;
    time_val = '0;
    case (k)
      KIND_L2G: begin
        has_time = 1'b1;
        time_val = to_global(ts);
      end
      KIND_STEP: begin
        now          = to_global(ts);
        lbase_mirror = ts;
        gbase_mirror = now + stp;
      end
      KIND_RATE: begin
        now          = to_global(ts);
        lbase_mirror = ts;
        gbase_mirror = now;
        // a zero rate latches the bases but keeps the old rate
        if (nr != '0) cur_rate = {1'b0, nr};
      end
      default: begin
        has_time = 1'b1;
        time_val = to_local(ts);
      end
    endcase
  endtask

  // Present one item, hold it until taken, then record what it should produce
  task automatic send_item(input kind_e k, input logic [63:0] ts, input logic [63:0] stp,
                           input logic [32:0] nr);
    bit          has_time;
    logic [63:0] time_val;
    if (idle_on && $urandom_range(99) < 17) begin
      start_i <= 1'b0;
      repeat (($urandom_range(3) == 0) ? $urandom_range(110, 1) : $urandom_range(3, 1))
        @(posedge clk_i);
    end
    start_i     <= 1'b1;
    kind_i      <= k;
    timestamp_i <= ts;
    step_ns_i   <= stp;
    new_rate_i  <= nr;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_item(k, ts, stp, nr, has_time, time_val);
    if (has_time) expected_times.push_back(time_val);
  endtask

  // Hold off until every pending result is back and the block has settled
  task automatic wait_idle();
    start_i <= 1'b0;
    while (expected_times.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_correction(input logic [63:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    corr_ns = value;
  endtask

  // Offset a time by a small, medium or arbitrary amount
  function automatic logic [63:0] pick_near(logic [63:0] center);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(4))
      0:       return r;
      1, 2:    return center + {{44{r[19]}}, r[19:0]};
      default: return center + {{24{r[39]}}, r[39:0]};
    endcase
  endfunction

  // Mostly near nominal, sometimes anything, a tiny rate or zero
  function automatic logic [32:0] pick_rate();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return NOM_RATE[32:0] + {{13{r[19]}}, r[19:0]};
      6, 7:             return {r[0], $urandom};
      8:                return 33'(r[3:0]) + 33'd1;
      default:          return '0;
    endcase
  endfunction

  task automatic send_random_item();
    kind_e       k;
    logic [63:0] ts;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35)      k = KIND_L2G;
    else if (pick < 70) k = KIND_G2L;
    else if (pick < 85) k = KIND_STEP;
    else                k = KIND_RATE;
    // aim at times close to the current bases so conversions stay meaningful
    if (k == KIND_G2L) ts = pick_near(to_global(lbase_mirror));
    else               ts = pick_near(lbase_mirror);
    send_item(k, ts, pick_near(64'd0), pick_rate());
  endtask

  // Reset values, time extremes, steps, rate extremes, zero rate, quotient wrap
  task automatic test_directed_extremes();
    idle_on = 1'b1;
    send_item(KIND_L2G,  64'd0,     64'd0,    33'd0);
    send_item(KIND_G2L,  64'd0,     64'd0,    33'd0);
    send_item(KIND_L2G,  MAX_TIME,  MIN_TIME, 33'h1_FFFF_FFFF);
    send_item(KIND_L2G,  MIN_TIME,  MAX_TIME, 33'h1_FFFF_FFFF);
    send_item(KIND_G2L,  MAX_TIME,  '1,       33'h1_FFFF_FFFF);
    send_item(KIND_G2L,  MIN_TIME,  '1,       33'd0);
    send_item(KIND_L2G,  '1,        '1,       '1);
    send_item(KIND_STEP, 64'd1000,  MAX_TIME, 33'd0);
    send_item(KIND_L2G,  64'd1000,  64'd0,    33'd0);
    send_item(KIND_STEP, MIN_TIME,  MIN_TIME, 33'd0);
    send_item(KIND_G2L,  64'd0,     64'd0,    33'd0);
    // unit rate makes the inverse quotient overflow 64 bits
    send_item(KIND_RATE, 64'd0,     64'd0,    33'd1);
    send_item(KIND_G2L,  MAX_TIME,  64'd0,    33'd0);
    send_item(KIND_L2G,  MAX_TIME,  64'd0,    33'd0);
    send_item(KIND_RATE, 64'd5,     64'd0,    33'h1_FFFF_FFFF);
    send_item(KIND_L2G,  MIN_TIME,  64'd0,    33'd0);
    send_item(KIND_G2L,  64'd123,   64'd0,    33'd0);
    // zero rate: latch only
    send_item(KIND_RATE, 64'd7,     64'd0,    33'd0);
    send_item(KIND_L2G,  64'd1 << 40, 64'd0,  33'd0);
    send_item(KIND_G2L,  64'd1 << 40, 64'd0,  33'd0);
    send_item(KIND_RATE, 64'd0,     64'd0,    NOM_RATE[32:0]);
    send_item(KIND_L2G,  -64'd1,    64'd0,    33'd0);
  endtask

  // Correction at its extremes and a few ordinary values
  task automatic test_correction_extremes();
    logic [63:0] corr;
    for (int v = 0; v < 5; v++) begin
      case (v)
        0:       corr = MAX_TIME;
        1:       corr = MIN_TIME;
        2:       corr = '1;
        3:       corr = 64'd1;
        default: corr = {$urandom, $urandom};
      endcase
      set_correction(corr);
      send_item(KIND_L2G,  pick_near(lbase_mirror), 64'd0, 33'd0);
      send_item(KIND_G2L,  pick_near(to_global(lbase_mirror)), 64'd0, 33'd0);
      send_item(KIND_STEP, pick_near(lbase_mirror), pick_near(64'd0), 33'd0);
      send_item(KIND_L2G,  pick_near(lbase_mirror), 64'd0, 33'd0);
      send_item(KIND_G2L,  pick_near(to_global(lbase_mirror)), 64'd0, 33'd0);
    end
  endtask

  // Random traffic in phases, each with its own correction
  task automatic test_random_traffic();
    logic [63:0] corr;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       corr = 64'd0;
        1:       corr = 64'($urandom_range(100000));
        2:       corr = MAX_TIME;
        3:       corr = MIN_TIME;
        4:       corr = {$urandom, $urandom};
        default: corr = '1;
      endcase
      set_correction(corr);
      // one phase runs back to back with no idle cycles
      idle_on = (phase != 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 4 && n == ITEMS_PER_PHASE / 2) wait_idle();
        send_random_item();
      end
    end
  endtask

  // Compare each result with the oldest pending expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_times.size() == 0) begin
        $error("converted_time: no result expected, got %h", converted_time_o);
        mismatch_count++;
      end else begin
        want_time = expected_times.pop_front();
        if (converted_time_o !== want_time) begin
          $error("converted_time: expected %h, actual %h", want_time, converted_time_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    kind_i         = KIND_L2G;
    timestamp_i    = '0;
    step_ns_i      = '0;
    new_rate_i     = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    idle_on        = 1'b0;
    mismatch_count = 0;
    corr_ns        = '0;
    lbase_mirror   = '0;
    gbase_mirror   = '0;
    cur_rate       = NOM_RATE;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_correction_extremes();
    test_random_traffic();

    // drain, then watch for stray results
    start_i <= 1'b0;
    for (int c = 0; c < 2000 && expected_times.size() != 0; c++) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_times.size() != 0) begin
      $error("converted_time: %0d results never arrived", expected_times.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
